### rtl/signed_decimal_ascii_formatter_core_defines.svh
// assertion macros used by the checker file sdaf_checker.sv
// needs a clock named clk and an active-high reset named rst in scope
`ifndef SIGNED_DECIMAL_ASCII_FORMATTER_CORE_DEFINES_SVH
`define SIGNED_DECIMAL_ASCII_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define SDAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define SDAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that is also checked while reset is high
`define SDAF_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdaf_pkg.sv
// shared constants and types for the signed decimal ascii formatter
// no dependencies
package sdaf_pkg;

  // default widths and reset values
  localparam int        DEFAULT_VALUE_WIDTH = 32;
  localparam logic [7:0] DEFAULT_TAG_CHAR   = 8'd84;

  // conversion pipeline: value bits handled per stage
  localparam int BITS_PER_STAGE = 4;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // character emitter states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_SIGN,
    ST_DIGIT
  } emit_state_t;

endpackage

### rtl/signed_decimal_ascii_formatter_core.sv
// signed integer to decimal ascii formatter, top level
// depends on sdaf_pkg
//
//   channel | direction | ports                            | transfer when
//   --------+-----------+----------------------------------+------------------------
//   in      | input     | number                           | in_valid & in_ready
//   out     | output    | ascii_char, last_char            | out_valid & out_ready
//   cfg     | input     | cfg_wr_data (tag character)      | cfg_wr_en
//
// A value passes one negate stage, ceil(VALUE_WIDTH/4) double-dabble stages (up to
// four shift-add-3 steps each), a leading-digit stage and the character emitter.
// Each value leaves as the tag, an optional sign and 1 to NUM_DIGITS digits (10 at
// VALUE_WIDTH 32), one character per cycle through the output register while
// out_ready is high; that sets the sustained rate.
// rst is synchronous, clears all valid bits and the emitter state, restores the tag.
// A stall on out holds each stage whose successor is full; nothing is dropped.
module signed_decimal_ascii_formatter_core #(
  parameter int VALUE_WIDTH = sdaf_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] number,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             ascii_char,
  output logic                   last_char
);

  localparam int BPS        = sdaf_pkg::BITS_PER_STAGE;
  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int NSTG       = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  // a block of double-dabble steps: add 3 to digits above 4, shift in the next bit
  function automatic logic [BCD_W+VALUE_WIDTH-1:0] dabble(
    input logic [BCD_W-1:0]       b_in,
    input logic [VALUE_WIDTH-1:0] m_in,
    input int                     base
  );
    logic [BCD_W-1:0]       b;
    logic [VALUE_WIDTH-1:0] m;
    b = b_in;
    m = m_in;
    for (int j = 0; j < BPS; j++) begin
      if (base + j < VALUE_WIDTH) begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
          if (b[d*4 +: 4] >= 4'd5) begin
            b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
          end
        end
        b = {b[BCD_W-2:0], m[VALUE_WIDTH-1]};
        m = {m[VALUE_WIDTH-2:0], 1'b0};
      end
    end
    return {b, m};
  endfunction

  // tag register
  logic [7:0] tag_char;

  // conversion pipeline, stage 0 holds the magnitude
  logic [NSTG:0]            vld;
  logic [NSTG:0]            adv;
  logic [VALUE_WIDTH-1:0]   mag_q [0:NSTG];
  logic [BCD_W-1:0]         bcd_q [0:NSTG];
  logic                     neg_q [0:NSTG];

  // leading-digit stage
  logic                     lead_vld;
  logic                     lead_adv;
  logic [BCD_W-1:0]         lead_bcd;
  logic                     lead_neg;
  logic [IDX_W-1:0]         lead_idx;
  logic [IDX_W-1:0]         lead_idx_next;

  // character emitter
  sdaf_pkg::emit_state_t    state, state_next;
  logic [BCD_W-1:0]         ser_bcd;
  logic                     ser_neg;
  logic [IDX_W-1:0]         ser_idx, ser_idx_next;
  logic                     emit;
  logic                     load;
  logic [7:0]               char_next;
  logic                     last_next;
  logic [3:0]               cur_digit;

  // tag register write
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_char <= sdaf_pkg::DEFAULT_TAG_CHAR;
    end else if (cfg_wr_en) begin
      tag_char <= cfg_wr_data;
    end
  end

  // stage advance chain, back to front
  always_comb begin
    adv[NSTG] = !vld[NSTG] || lead_adv;
    for (int s = NSTG - 1; s >= 0; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end

  assign in_ready = adv[0];

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s <= NSTG; s++) begin
        if (adv[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // pipeline data: negate into a magnitude, then the dabble stages
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      neg_q[0] <= number[VALUE_WIDTH-1];
      mag_q[0] <= number[VALUE_WIDTH-1] ? (~number + VALUE_WIDTH'(1)) : number;
      bcd_q[0] <= '0;
    end
    for (int s = 1; s <= NSTG; s++) begin
      if (adv[s]) begin
        neg_q[s]               <= neg_q[s-1];
        {bcd_q[s], mag_q[s]}   <= dabble(bcd_q[s-1], mag_q[s-1], (s - 1) * BPS);
      end
    end
  end

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    lead_idx_next = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_q[NSTG][d*4 +: 4] != 4'd0) begin
        lead_idx_next = IDX_W'(d);
      end
    end
  end

  assign lead_adv = !lead_vld || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_vld <= 1'b0;
    end else if (lead_adv) begin
      lead_vld <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (lead_adv) begin
      lead_bcd <= bcd_q[NSTG];
      lead_neg <= neg_q[NSTG];
      lead_idx <= lead_idx_next;
    end
  end

  // emitter: one character per free output slot
  assign emit      = (state != sdaf_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign cur_digit = ser_bcd[ser_idx*4 +: 4];

  always_comb begin
    state_next   = state;
    ser_idx_next = ser_idx;
    char_next    = tag_char;
    last_next    = 1'b0;
    case (state)
      sdaf_pkg::ST_IDLE: begin
        char_next = tag_char;
      end
      sdaf_pkg::ST_TAG: begin
        char_next = tag_char;
        if (emit) begin
          state_next = ser_neg ? sdaf_pkg::ST_SIGN : sdaf_pkg::ST_DIGIT;
        end
      end
      sdaf_pkg::ST_SIGN: begin
        char_next = sdaf_pkg::CHAR_MINUS;
        if (emit) begin
          state_next = sdaf_pkg::ST_DIGIT;
        end
      end
      sdaf_pkg::ST_DIGIT: begin
        char_next = sdaf_pkg::CHAR_ZERO + {4'd0, cur_digit};
        last_next = (ser_idx == '0);
        if (emit) begin
          if (last_next) begin
            state_next = sdaf_pkg::ST_IDLE;
          end else begin
            ser_idx_next = ser_idx - IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = sdaf_pkg::ST_IDLE;
      end
    endcase
    load = lead_vld && (state_next == sdaf_pkg::ST_IDLE);
    if (load) begin
      state_next   = sdaf_pkg::ST_TAG;
      ser_idx_next = lead_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    ser_idx <= ser_idx_next;
    if (load) begin
      ser_bcd <= lead_bcd;
      ser_neg <= lead_neg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ascii_char <= char_next;
      last_char  <= last_next;
    end
  end

endmodule

### rtl/sdaf_checker.sv
// port-level checker for the formatter, bound to the top level
// depends on sdaf_pkg and signed_decimal_ascii_formatter_core_defines.svh
`include "signed_decimal_ascii_formatter_core_defines.svh"

module sdaf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] ascii_char,
  input logic       last_char
);

  // helper terms for the checks below
  logic       is_digit;
  logic       out_stall;
  logic [8:0] out_word;

  assign is_digit  = (ascii_char >= sdaf_pkg::CHAR_ZERO) &&
                     (ascii_char <= sdaf_pkg::CHAR_NINE);
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {ascii_char, last_char};

  // reset empties the output register
  `SDAF_ASSERT_RESET(a_rst_out_empty, rst, !out_valid, "output valid after reset")

  // reset leaves the pipeline free to take an item
  `SDAF_ASSERT_RESET(a_rst_in_ready, rst, in_ready, "input not ready after reset")

  // a run always ends on a decimal digit
  `SDAF_ASSERT_NOW(a_last_is_digit, out_valid && last_char, is_digit, "run ends on a non-digit")

  // a stalled character holds
  `SDAF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled output moved")

endmodule

bind signed_decimal_ascii_formatter_core sdaf_checker u_sdaf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .ascii_char (ascii_char),
  .last_char  (last_char)
);
